// ----- design/tilt_pkg.sv -----
// Shared constants for the tilt angle unit: CORDIC arctangent table and angle units.
// Used by tilt_cordic and accel_tilt_angles_unit; depends on nothing else.
package tilt_pkg;

   localparam int ACC_W         = 32;
   localparam int ACC_FRAC      = 20;
   localparam int GUARD_BITS    = 8;
   localparam int CORDIC_STAGES = 20;

   localparam logic signed [ACC_W-1:0] HALF_TURN    = 32'sd188743680;
   localparam logic signed [ACC_W-1:0] QUARTER_TURN = 32'sd94371840;
   localparam logic signed [ACC_W-1:0] HALF_DEG     = 32'sd180;
   localparam logic signed [ACC_W-1:0] QUARTER_DEG  = 32'sd90;

   localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
      32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
      32'sd1876857,  32'sd938658,   32'sd469357,   32'sd234682,  32'sd117342,
      32'sd58671,    32'sd29335,    32'sd14668,    32'sd7334,    32'sd3667,
      32'sd1833,     32'sd917,      32'sd458,      32'sd229,     32'sd115
   };

endpackage

// ----- design/accel_tilt_angles_unit.sv -----
// Top level of the tilt angle unit: roll and pitch from one acceleration sample.
// Instantiates tilt_sqrt and tilt_cordic; depends on tilt_pkg.
//
// Usage: drive req_accel_x/y/z and raise start for one cycle per sample. A
// sample transfers at each rising edge with start high and busy low; busy is
// always low, so one sample may transfer in every cycle.
// Each result appears on rsp_roll_angle and rsp_pitch_angle for exactly one
// cycle with rsp_valid high. Results leave in sample order.
// Throughput is one sample per cycle. The path runs through the square root
// pipeline (SAMPLE_BITS + 8 stages, one root bit per stage), followed by the
// 20-stage CORDIC pair, plus five stages for input capture, squaring, the
// sum, operand setup and final rounding.
// Angles are signed, in 1/2^ANGLE_FRAC_BITS degree: roll within +-180 and
// pitch within +-90 degrees.
// Synchronous reset clears all valid bits; samples in flight are dropped.
// The receiver cannot stall, so no back pressure exists.
module accel_tilt_angles_unit #(
   parameter int SAMPLE_BITS     = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [SAMPLE_BITS-1:0]     req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]     req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]     req_accel_z,
   output logic                              rsp_valid,
   output logic signed [ANGLE_FRAC_BITS+8:0] rsp_roll_angle,
   output logic signed [ANGLE_FRAC_BITS+7:0] rsp_pitch_angle
);

   localparam int W      = SAMPLE_BITS + tilt_pkg::GUARD_BITS;
   localparam int VW     = 2 * W;
   localparam int SW     = 3 * W;
   localparam int DW     = W + 3;
   localparam int AW     = tilt_pkg::ACC_W;
   localparam int SH     = tilt_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ROLL_W = ANGLE_FRAC_BITS + 9;
   localparam int PITCH_W = ANGLE_FRAC_BITS + 8;

   logic                 a_valid_ff;
   logic signed [W-1:0]  a_x_ff, a_y_ff, a_z_ff;
   logic                 b_valid_ff;
   logic signed [W-1:0]  b_x_ff, b_y_ff, b_z_ff;
   logic [VW-2:0]        b_ysq_ff, b_zsq_ff;
   logic signed [VW-1:0] y_prod, z_prod;
   logic                 c_valid_ff;
   logic [VW-1:0]        c_sum_ff;
   logic [SW-1:0]        c_side_ff;

   logic                 s_valid;
   logic [W-1:0]         s_root;
   logic [SW-1:0]        s_side;
   logic signed [W-1:0]  s_x, s_y, s_z;

   logic                 p_valid_ff;
   logic signed [DW-1:0] p_rx_ff, p_ry_ff, p_px_ff, p_py_ff;
   logic signed [AW-1:0] p_racc_ff, p_pacc_ff;
   logic                 p_rhold_ff, p_phold_ff;
   logic signed [DW-1:0] p_rx_in, p_ry_in, p_px_in, p_py_in;
   logic signed [AW-1:0] p_racc_in, p_pacc_in;
   logic                 p_rhold_in, p_phold_in;

   logic                 roll_valid, pitch_valid;
   logic signed [AW-1:0] roll_acc, pitch_acc;
   logic signed [AW-1:0] roll_rnd, pitch_rnd, roll_lim, pitch_lim;
   logic signed [AW-1:0] roll_clip, pitch_clip;

   logic                      rsp_valid_ff;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_x_ff    <= {req_accel_x, {tilt_pkg::GUARD_BITS{1'b0}}};
      a_y_ff    <= {req_accel_y, {tilt_pkg::GUARD_BITS{1'b0}}};
      a_z_ff    <= {req_accel_z, {tilt_pkg::GUARD_BITS{1'b0}}};
      b_x_ff    <= a_x_ff;
      b_y_ff    <= a_y_ff;
      b_z_ff    <= a_z_ff;
      b_ysq_ff  <= y_prod[VW-2:0];
      b_zsq_ff  <= z_prod[VW-2:0];
      c_sum_ff  <= VW'(b_ysq_ff) + VW'(b_zsq_ff);
      c_side_ff <= {b_x_ff, b_y_ff, b_z_ff};
   end

   assign y_prod = a_y_ff * a_y_ff;
   assign z_prod = a_z_ff * a_z_ff;

   tilt_sqrt #(
      .VW (VW),
      .RW (W),
      .SW (SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_value  (c_sum_ff),
      .in_side   (c_side_ff),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   assign s_x = s_side[SW-1:2*W];
   assign s_y = s_side[2*W-1:W];
   assign s_z = s_side[W-1:0];

   always_comb begin
      p_rx_in    = DW'(s_z);
      p_ry_in    = DW'(s_y);
      p_racc_in  = '0;
      p_rhold_in = 1'b0;
      if (s_y == '0) begin
         p_rhold_in = 1'b1;
         p_racc_in  = s_z[W-1] ? tilt_pkg::HALF_TURN : '0;
      end else if (s_z[W-1]) begin
         p_rx_in   = -DW'(s_z);
         p_ry_in   = -DW'(s_y);
         p_racc_in = s_y[W-1] ? -tilt_pkg::HALF_TURN : tilt_pkg::HALF_TURN;
      end

      p_px_in    = DW'($signed({1'b0, s_root}));
      p_py_in    = -DW'(s_x);
      p_pacc_in  = '0;
      p_phold_in = 1'b0;
      if (s_root == '0) begin
         p_phold_in = 1'b1;
         if (s_x == '0) begin
            p_pacc_in = '0;
         end else if (s_x[W-1]) begin
            p_pacc_in = tilt_pkg::QUARTER_TURN;
         end else begin
            p_pacc_in = -tilt_pkg::QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= s_valid;
      end
      p_rx_ff    <= p_rx_in;
      p_ry_ff    <= p_ry_in;
      p_racc_ff  <= p_racc_in;
      p_rhold_ff <= p_rhold_in;
      p_px_ff    <= p_px_in;
      p_py_ff    <= p_py_in;
      p_pacc_ff  <= p_pacc_in;
      p_phold_ff <= p_phold_in;
   end

   tilt_cordic #(
      .DW (DW)
   ) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid_ff),
      .in_x      (p_rx_ff),
      .in_y      (p_ry_ff),
      .in_acc    (p_racc_ff),
      .in_hold   (p_rhold_ff),
      .out_valid (roll_valid),
      .out_acc   (roll_acc)
   );

   tilt_cordic #(
      .DW (DW)
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid_ff),
      .in_x      (p_px_ff),
      .in_y      (p_py_ff),
      .in_acc    (p_pacc_ff),
      .in_hold   (p_phold_ff),
      .out_valid (pitch_valid),
      .out_acc   (pitch_acc)
   );

   always_comb begin
      roll_rnd  = (roll_acc + (AW'(1) << (SH - 1))) >>> SH;
      pitch_rnd = (pitch_acc + (AW'(1) << (SH - 1))) >>> SH;
      roll_lim  = tilt_pkg::HALF_DEG <<< ANGLE_FRAC_BITS;
      pitch_lim = tilt_pkg::QUARTER_DEG <<< ANGLE_FRAC_BITS;
      roll_clip = roll_rnd;
      if (roll_rnd > roll_lim) begin
         roll_clip = roll_lim;
      end else if (roll_rnd < -roll_lim) begin
         roll_clip = -roll_lim;
      end
      pitch_clip = pitch_rnd;
      if (pitch_rnd > pitch_lim) begin
         pitch_clip = pitch_lim;
      end else if (pitch_rnd < -pitch_lim) begin
         pitch_clip = -pitch_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= roll_valid && pitch_valid;
      end
      roll_ff  <= roll_clip[ROLL_W-1:0];
      pitch_ff <= pitch_clip[PITCH_W-1:0];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;

endmodule

// ----- design/tilt_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries a side word along with each value; uses no package.
module tilt_sqrt #(
   parameter int VW = 48,
   parameter int RW = 24,
   parameter int SW = 72
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [VW-1:0] in_value,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [RW-1:0] out_root,
   output logic [SW-1:0] out_side
);

   localparam int TW = VW + 1;

   logic [VW-1:0] rem_ff   [RW];
   logic [RW-1:0] root_ff  [RW];
   logic [SW-1:0] side_ff  [RW];
   logic [RW-1:0] valid_ff;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int BIT = RW - 1 - k;
      logic [VW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [SW-1:0] side_prev;
      logic          valid_prev;
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_ext;
      logic [VW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_value;
         assign root_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial   = (TW'(root_prev) << (BIT + 1)) | (TW'(1) << (2 * BIT));
         rem_ext = TW'(rem_prev);
         if (rem_ext >= trial) begin
            rem_in  = VW'(rem_ext - trial);
            root_in = root_prev | (RW'(1) << BIT);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

// ----- design/tilt_cordic.sv -----
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on tilt_pkg for the arctangent table and the accumulator width.
module tilt_cordic #(
   parameter int DW = 27
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [DW-1:0]             in_x,
   input  logic signed [DW-1:0]             in_y,
   input  logic signed [tilt_pkg::ACC_W-1:0] in_acc,
   input  logic                             in_hold,
   output logic                             out_valid,
   output logic signed [tilt_pkg::ACC_W-1:0] out_acc
);

   localparam int N = tilt_pkg::CORDIC_STAGES;

   logic signed [DW-1:0]             x_ff    [N];
   logic signed [DW-1:0]             y_ff    [N];
   logic signed [tilt_pkg::ACC_W-1:0] acc_ff  [N];
   logic [N-1:0]                     hold_ff;
   logic [N-1:0]                     valid_ff;

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic signed [DW-1:0]             x_prev, y_prev, dx, dy, x_in, y_in;
      logic signed [tilt_pkg::ACC_W-1:0] acc_prev, acc_in;
      logic                             hold_prev, valid_prev;

      if (k == 0) begin : g_first
         assign x_prev     = in_x;
         assign y_prev     = in_y;
         assign acc_prev   = in_acc;
         assign hold_prev  = in_hold;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign x_prev     = x_ff[k-1];
         assign y_prev     = y_ff[k-1];
         assign acc_prev   = acc_ff[k-1];
         assign hold_prev  = hold_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         dx = x_prev >>> k;
         dy = y_prev >>> k;
         if (!y_prev[DW-1]) begin
            x_in   = x_prev + dy;
            y_in   = y_prev - dx;
            acc_in = acc_prev + tilt_pkg::ATAN_TAB[k];
         end else begin
            x_in   = x_prev - dy;
            y_in   = y_prev + dx;
            acc_in = acc_prev - tilt_pkg::ATAN_TAB[k];
         end
         if (hold_prev) begin
            acc_in = acc_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         x_ff[k]    <= x_in;
         y_ff[k]    <= y_in;
         acc_ff[k]  <= acc_in;
         hold_ff[k] <= hold_prev;
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_acc   = acc_ff[N-1];

endmodule

// ----- design/tilt_checker.sv -----
// Port-level checks for accel_tilt_angles_unit and the bind that attaches them.
// Depends only on the top level's ports and parameters.
module tilt_checker #(
   parameter int SAMPLE_BITS     = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic signed [SAMPLE_BITS-1:0]     req_accel_x,
   input logic signed [SAMPLE_BITS-1:0]     req_accel_y,
   input logic signed [SAMPLE_BITS-1:0]     req_accel_z,
   input logic                              rsp_valid,
   input logic signed [ANGLE_FRAC_BITS+8:0] rsp_roll_angle,
   input logic signed [ANGLE_FRAC_BITS+7:0] rsp_pitch_angle
);

   localparam int LAT = SAMPLE_BITS + 33;
   localparam int ROLL_LIM  = 180 * (2 ** ANGLE_FRAC_BITS);
   localparam int PITCH_LIM = 90 * (2 ** ANGLE_FRAC_BITS);

   logic zero_in;

   assign zero_in = start && !busy && req_accel_x == '0 && req_accel_y == '0 &&
                    req_accel_z == '0;

   a_transfer_returns: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("A transferred sample produced no result in time.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("A result appeared without a matching sample.");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_roll_angle) <= ROLL_LIM && int'(rsp_roll_angle) >= -ROLL_LIM &&
                     int'(rsp_pitch_angle) <= PITCH_LIM &&
                     int'(rsp_pitch_angle) >= -PITCH_LIM))
      else $error("An angle left its range.");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      zero_in ##LAT rsp_valid |-> rsp_roll_angle == '0 && rsp_pitch_angle == '0)
      else $error("An all-zero sample did not give zero angles.");

endmodule

bind accel_tilt_angles_unit tilt_checker #(
   .SAMPLE_BITS     (SAMPLE_BITS),
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_tilt_checker (.*);
